>>> design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checks sampled on clk, off while arst_n is low
`define SPT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition in one cycle implies expression in the next
`define SPT_ASSERT_NEXT(label, cond, expr, msg) \
	`SPT_ASSERT(label, (cond) |=> (expr), msg)

`endif

>>> design/spt_pkg.sv
package spt_pkg;

	localparam int TIME_WIDTH_DEF = 48;
	localparam int SCALE_FRAC_DEF = 16;
	localparam int SCALE_W = 32;
	localparam int CFG_IDX_W = 2;
	localparam int KIND_W = 3;

	localparam logic [SCALE_W-1:0] START_SCALE_RST = 32'd65536;

	typedef enum logic [KIND_W-1:0] {
		K_QUERY     = 3'd0,
		K_PAUSE     = 3'd1,
		K_RESUME    = 3'd2,
		K_SET_SCALE = 3'd3,
		K_SET_EPOCH = 3'd4,
		K_SCHED     = 3'd5,
		K_CLEAR     = 3'd6
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_START_EPOCH  = 2'd0,
		CFG_START_WALL   = 2'd1,
		CFG_START_PAUSED = 2'd2,
		CFG_START_SCALE  = 2'd3
	} cfg_idx_t;

	// what the accumulate stage does with one request
	typedef struct packed {
		logic load;
		logic freeze;
		logic reanchor;
		logic resume;
		logic set_epoch;
		logic paused;
		logic armed;
		logic bad;
	} ops_t;

endpackage

>>> design/scaled_pausable_time_base.sv
// Scaled pausable time base: every request (query, pause, resume, set scale, set epoch,
// schedule pause, clear schedule) carries the current wall time and returns one result
// with the simulated time after the command, saturated to the signed time range. One
// request is accepted per clock unless in_stall signals out_stall back-pressure, and
// throughput is held there because the control state update and the saturating add
// into the simulated-time anchor are combinational into their state registers. The
// multiply of elapsed wall time by the Q16.16 scale is split into two partial products
// and one rounding stage in between. Start registers are loaded into the state by the
// first request after reset; later writes have no effect until the next reset.
`include "assert_macros.svh"

module scaled_pausable_time_base #(
	parameter int TIME_WIDTH = spt_pkg::TIME_WIDTH_DEF,
	parameter int SCALE_FRAC_BITS = spt_pkg::SCALE_FRAC_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [spt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [TIME_WIDTH-1:0]         cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [spt_pkg::KIND_W-1:0]    kind,
	input  logic signed [TIME_WIDTH-1:0]  wall_ms,
	input  logic signed [TIME_WIDTH-1:0]  arg_value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [TIME_WIDTH-1:0]  sim_time_ms,
	output logic signed [TIME_WIDTH-1:0]  epoch_ms,
	output logic [spt_pkg::SCALE_W-1:0]   rate_scale,
	output logic                          is_paused,
	output logic                          pause_pending,
	output logic signed [TIME_WIDTH-1:0]  pending_wall_ms,
	output logic                          bad_scale
);

	localparam int TW = TIME_WIDTH;
	localparam int SW = spt_pkg::SCALE_W;

	spt_pkg::cfg_idx_t cfg_idx_e;

	logic signed [TW-1:0] cfg_epoch_q;
	logic signed [TW-1:0] cfg_wall_q;
	logic                 cfg_paused_q;
	logic [SW-1:0]        cfg_scale_q;

	logic v1_q, v2_q, v3_q, v4_q, out_valid_q;
	logic rdy1, rdy2, rdy3, rdy4, rdy_o;
	logic take1, take2, take3, take4, take_o;

	logic [spt_pkg::KIND_W-1:0] kind_s1;
	logic signed [TW-1:0]       wall_s1;
	logic signed [TW-1:0]       arg_s1;

	logic [TW-1:0]        mag_s2;
	logic                 neg_s2, neg_s3, neg_s4;
	logic [SW-1:0]        mul_scale_s2;
	spt_pkg::ops_t        ops_s2, ops_s3, ops_s4;
	logic signed [TW-1:0] arg_s2, arg_s3, arg_s4;
	logic signed [TW-1:0] epoch_s2, epoch_s3, epoch_s4;
	logic [SW-1:0]        scale_s2, scale_s3, scale_s4;
	logic signed [TW-1:0] pend_s2, pend_s3, pend_s4;
	logic [TW-1:0]        q_s4;
	logic                 big_s4;

	assign cfg_ready = 1'b1;
	assign cfg_idx_e = spt_pkg::cfg_idx_t'(cfg_index);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_epoch_q <= '0;
			cfg_wall_q <= '0;
			cfg_paused_q <= 1'b0;
			cfg_scale_q <= spt_pkg::START_SCALE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_e)
				spt_pkg::CFG_START_EPOCH:  cfg_epoch_q <= cfg_data;
				spt_pkg::CFG_START_WALL:   cfg_wall_q <= cfg_data;
				spt_pkg::CFG_START_PAUSED: cfg_paused_q <= cfg_data[0];
				spt_pkg::CFG_START_SCALE:  cfg_scale_q <= cfg_data[SW-1:0];
				default: begin
				end
			endcase
		end
	end

	// each stage moves when the one after it is empty or moving
	assign rdy_o = !out_valid_q || !out_stall;
	assign rdy4 = !v4_q || rdy_o;
	assign rdy3 = !v3_q || rdy4;
	assign rdy2 = !v2_q || rdy3;
	assign rdy1 = !v1_q || rdy2;
	assign in_stall = !rdy1;

	assign take1 = in_valid && rdy1;
	assign take2 = v1_q && rdy2;
	assign take3 = v2_q && rdy3;
	assign take4 = v3_q && rdy4;
	assign take_o = v4_q && rdy_o;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy1) v1_q <= in_valid;
			if (rdy2) v2_q <= v1_q;
			if (rdy3) v3_q <= v2_q;
			if (rdy4) v4_q <= v3_q;
			if (rdy_o) out_valid_q <= v4_q;
		end
	end

	assign out_valid = out_valid_q;

	always_ff @(posedge clk) begin
		if (take1) begin
			kind_s1 <= kind;
			wall_s1 <= wall_ms;
			arg_s1 <= arg_value;
		end
		if (take3) begin
			neg_s3 <= neg_s2;
			ops_s3 <= ops_s2;
			arg_s3 <= arg_s2;
			epoch_s3 <= epoch_s2;
			scale_s3 <= scale_s2;
			pend_s3 <= pend_s2;
		end
		if (take4) begin
			neg_s4 <= neg_s3;
			ops_s4 <= ops_s3;
			arg_s4 <= arg_s3;
			epoch_s4 <= epoch_s3;
			scale_s4 <= scale_s3;
			pend_s4 <= pend_s3;
		end
	end

	spt_ctrl #(
		.TIME_WIDTH(TIME_WIDTH),
		.SCALE_FRAC_BITS(SCALE_FRAC_BITS)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.take(take2),
		.kind_s1(kind_s1),
		.wall_s1(wall_s1),
		.arg_s1(arg_s1),
		.cfg_epoch(cfg_epoch_q),
		.cfg_wall(cfg_wall_q),
		.cfg_paused(cfg_paused_q),
		.cfg_scale(cfg_scale_q),
		.mag_s2(mag_s2),
		.neg_s2(neg_s2),
		.mul_scale_s2(mul_scale_s2),
		.ops_s2(ops_s2),
		.arg_s2(arg_s2),
		.epoch_s2(epoch_s2),
		.scale_s2(scale_s2),
		.pend_s2(pend_s2)
	);

	spt_mul #(
		.TIME_WIDTH(TIME_WIDTH),
		.SCALE_FRAC_BITS(SCALE_FRAC_BITS)
	) u_mul (
		.clk(clk),
		.take3(take3),
		.take4(take4),
		.mag_s2(mag_s2),
		.scale_s2(mul_scale_s2),
		.q_s4(q_s4),
		.big_s4(big_s4)
	);

	spt_accum #(
		.TIME_WIDTH(TIME_WIDTH)
	) u_accum (
		.clk(clk),
		.arst_n(arst_n),
		.take(take_o),
		.q_s4(q_s4),
		.big_s4(big_s4),
		.neg_s4(neg_s4),
		.ops_s4(ops_s4),
		.arg_s4(arg_s4),
		.epoch_s4(epoch_s4),
		.scale_s4(scale_s4),
		.pend_s4(pend_s4),
		.cfg_epoch(cfg_epoch_q),
		.sim_time_ms(sim_time_ms),
		.epoch_ms(epoch_ms),
		.rate_scale(rate_scale),
		.is_paused(is_paused),
		.pause_pending(pause_pending),
		.pending_wall_ms(pending_wall_ms),
		.bad_scale(bad_scale)
	);

	`SPT_ASSERT_NEXT(a_keep_s1, v1_q && in_stall, v1_q, "held request dropped from input stage")
	`SPT_ASSERT_NEXT(a_drain, v4_q && !out_valid_q, out_valid_q, "finished request not moved to output")

endmodule

>>> design/spt_ctrl.sv
`include "assert_macros.svh"

module spt_ctrl #(
	parameter int TIME_WIDTH = spt_pkg::TIME_WIDTH_DEF,
	parameter int SCALE_FRAC_BITS = spt_pkg::SCALE_FRAC_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                take,
	input  logic [spt_pkg::KIND_W-1:0]          kind_s1,
	input  logic signed [TIME_WIDTH-1:0]        wall_s1,
	input  logic signed [TIME_WIDTH-1:0]        arg_s1,
	input  logic signed [TIME_WIDTH-1:0]        cfg_epoch,
	input  logic signed [TIME_WIDTH-1:0]        cfg_wall,
	input  logic                                cfg_paused,
	input  logic [spt_pkg::SCALE_W-1:0]         cfg_scale,
	output logic [TIME_WIDTH-1:0]               mag_s2,
	output logic                                neg_s2,
	output logic [spt_pkg::SCALE_W-1:0]         mul_scale_s2,
	output spt_pkg::ops_t                       ops_s2,
	output logic signed [TIME_WIDTH-1:0]        arg_s2,
	output logic signed [TIME_WIDTH-1:0]        epoch_s2,
	output logic [spt_pkg::SCALE_W-1:0]         scale_s2,
	output logic signed [TIME_WIDTH-1:0]        pend_s2
);

	localparam int TW = TIME_WIDTH;
	localparam int SW = spt_pkg::SCALE_W;
	localparam logic [SW-1:0] UNITY = SW'(1) << SCALE_FRAC_BITS;
	localparam logic [TW:0] SCALE_MAX = (TW+1)'({SW{1'b1}});

	logic                 started_q;
	logic signed [TW-1:0] anchor_wall_q;
	logic [SW-1:0]        scale_q;
	logic signed [TW-1:0] epoch_q;
	logic                 frozen_q;
	logic                 armed_q;
	logic signed [TW-1:0] armed_wall_q;

	logic signed [TW-1:0] aw_b;
	logic [SW-1:0]        sc_b;
	logic signed [TW-1:0] ep_b;
	logic                 fr_b;

	logic signed [TW-1:0] aw_n;
	logic [SW-1:0]        sc_n;
	logic signed [TW-1:0] ep_n;
	logic                 fr_n;
	logic                 arm_n;
	logic signed [TW-1:0] armw_n;

	logic [TW:0]          diff_fw;
	logic [TW:0]          diff_bw;
	logic                 neg;
	logic [TW-1:0]        mag;

	spt_pkg::kind_t       kind_e;
	spt_pkg::ops_t        ops_n;
	logic                 bad;
	logic                 clr;
	logic                 due;

	assign kind_e = spt_pkg::kind_t'(kind_s1);

	// state as seen by this request, start values on the first one
	assign aw_b = started_q ? anchor_wall_q : cfg_wall;
	assign sc_b = started_q ? scale_q : ((cfg_scale == '0) ? UNITY : cfg_scale);
	assign ep_b = started_q ? epoch_q : cfg_epoch;
	assign fr_b = started_q ? frozen_q : cfg_paused;

	assign diff_fw = {wall_s1[TW-1], wall_s1} - {aw_b[TW-1], aw_b};
	assign diff_bw = {aw_b[TW-1], aw_b} - {wall_s1[TW-1], wall_s1};
	assign neg = diff_fw[TW];
	assign mag = neg ? diff_bw[TW-1:0] : diff_fw[TW-1:0];

	assign bad = (kind_e == spt_pkg::K_SET_SCALE) &&
		(arg_s1[TW-1] || (arg_s1 == '0) || ({1'b0, arg_s1} > SCALE_MAX));
	assign clr = (kind_e == spt_pkg::K_CLEAR);
	assign due = !bad && !clr && armed_q && !fr_b && (wall_s1 >= armed_wall_q);

	always_comb begin
		ops_n = '0;
		ops_n.load = !started_q;
		ops_n.bad = bad;
		fr_n = fr_b;
		arm_n = armed_q;
		armw_n = armed_wall_q;
		aw_n = aw_b;
		sc_n = sc_b;
		ep_n = ep_b;
		if (clr) begin
			arm_n = 1'b0;
			armw_n = '0;
		end else if (!bad) begin
			if (due) begin
				fr_n = 1'b1;
				arm_n = 1'b0;
				armw_n = '0;
				ops_n.freeze = 1'b1;
			end
			unique case (kind_e)
				spt_pkg::K_PAUSE: begin
					if (!fr_n) begin
						fr_n = 1'b1;
						ops_n.freeze = 1'b1;
					end
				end
				spt_pkg::K_RESUME: begin
					if (fr_n) begin
						ops_n.resume = 1'b1;
						aw_n = wall_s1;
						fr_n = 1'b0;
					end
				end
				spt_pkg::K_SET_SCALE: begin
					if (!fr_n) begin
						ops_n.reanchor = 1'b1;
						aw_n = wall_s1;
					end
					sc_n = arg_s1[SW-1:0];
				end
				spt_pkg::K_SET_EPOCH: begin
					ops_n.set_epoch = 1'b1;
					ep_n = arg_s1;
					aw_n = wall_s1;
				end
				spt_pkg::K_SCHED: begin
					if (fr_n) begin
						arm_n = 1'b0;
						armw_n = '0;
					end else if (arg_s1 <= wall_s1) begin
						fr_n = 1'b1;
						arm_n = 1'b0;
						armw_n = '0;
						ops_n.freeze = 1'b1;
					end else begin
						arm_n = 1'b1;
						armw_n = arg_s1;
					end
				end
				default: begin
				end
			endcase
		end
		ops_n.paused = fr_n;
		ops_n.armed = arm_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			anchor_wall_q <= '0;
			scale_q <= spt_pkg::START_SCALE_RST;
			epoch_q <= '0;
			frozen_q <= 1'b0;
			armed_q <= 1'b0;
			armed_wall_q <= '0;
		end else if (take) begin
			started_q <= 1'b1;
			anchor_wall_q <= aw_n;
			scale_q <= sc_n;
			epoch_q <= ep_n;
			frozen_q <= fr_n;
			armed_q <= arm_n;
			armed_wall_q <= armw_n;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			mag_s2 <= mag;
			neg_s2 <= neg;
			mul_scale_s2 <= sc_b;
			ops_s2 <= ops_n;
			arg_s2 <= arg_s1;
			epoch_s2 <= ep_n;
			scale_s2 <= sc_n;
			pend_s2 <= arm_n ? armw_n : '0;
		end
	end

	`SPT_ASSERT_NEXT(a_pause_freezes, take && kind_e == spt_pkg::K_PAUSE && !ops_n.bad, frozen_q, "pause left the time base running")

endmodule

>>> design/spt_mul.sv
module spt_mul #(
	parameter int TIME_WIDTH = spt_pkg::TIME_WIDTH_DEF,
	parameter int SCALE_FRAC_BITS = spt_pkg::SCALE_FRAC_DEF
) (
	input  logic                        clk,
	input  logic                        take3,
	input  logic                        take4,
	input  logic [TIME_WIDTH-1:0]       mag_s2,
	input  logic [spt_pkg::SCALE_W-1:0] scale_s2,
	output logic [TIME_WIDTH-1:0]       q_s4,
	output logic                        big_s4
);

	localparam int TW = TIME_WIDTH;
	localparam int SW = spt_pkg::SCALE_W;
	localparam int F = SCALE_FRAC_BITS;
	localparam int LW = TW / 2;
	localparam int HW = TW - LW;
	localparam int PLW = LW + SW;
	localparam int PHW = HW + SW;
	localparam int PW = TW + SW;
	localparam logic [PW-1:0] HALF = PW'(1) << (F - 1);

	logic [PLW-1:0] pp_lo_s3;
	logic [PHW-1:0] pp_hi_s3;
	logic [PW-1:0]  prod;

	// two partial products of magnitude times scale
	always_ff @(posedge clk) begin
		if (take3) begin
			pp_lo_s3 <= PLW'(mag_s2[LW-1:0]) * PLW'(scale_s2);
			pp_hi_s3 <= PHW'(mag_s2[TW-1:LW]) * PHW'(scale_s2);
		end
	end

	// combine, round half up on the magnitude, drop the fraction
	assign prod = {pp_hi_s3, {LW{1'b0}}} + PW'(pp_lo_s3) + HALF;

	always_ff @(posedge clk) begin
		if (take4) begin
			q_s4 <= prod[F+TW-1:F];
			big_s4 <= |prod[PW-1:F+TW];
		end
	end

endmodule

>>> design/spt_accum.sv
`include "assert_macros.svh"

module spt_accum #(
	parameter int TIME_WIDTH = spt_pkg::TIME_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         take,
	input  logic [TIME_WIDTH-1:0]        q_s4,
	input  logic                         big_s4,
	input  logic                         neg_s4,
	input  spt_pkg::ops_t                ops_s4,
	input  logic signed [TIME_WIDTH-1:0] arg_s4,
	input  logic signed [TIME_WIDTH-1:0] epoch_s4,
	input  logic [spt_pkg::SCALE_W-1:0]  scale_s4,
	input  logic signed [TIME_WIDTH-1:0] pend_s4,
	input  logic signed [TIME_WIDTH-1:0] cfg_epoch,
	output logic signed [TIME_WIDTH-1:0] sim_time_ms,
	output logic signed [TIME_WIDTH-1:0] epoch_ms,
	output logic [spt_pkg::SCALE_W-1:0]  rate_scale,
	output logic                         is_paused,
	output logic                         pause_pending,
	output logic signed [TIME_WIDTH-1:0] pending_wall_ms,
	output logic                         bad_scale
);

	localparam int TW = TIME_WIDTH;
	localparam logic [TW-1:0] T_MAX = {1'b0, {(TW-1){1'b1}}};
	localparam logic [TW-1:0] T_MIN = {1'b1, {(TW-1){1'b0}}};

	logic [TW-1:0] anchor_sim_q;
	logic [TW-1:0] frozen_sim_q;

	logic [TW-1:0] a0;
	logic [TW-1:0] f0;
	logic [TW+1:0] a0e;
	logic [TW+1:0] qe;
	logic [TW+1:0] sum;
	logic          ovf;
	logic          sat_neg;
	logic [TW-1:0] s_val;
	logic [TW-1:0] f1;
	logic [TW-1:0] a1;
	logic [TW-1:0] sim_n;

	assign a0 = ops_s4.load ? cfg_epoch : anchor_sim_q;
	assign f0 = ops_s4.load ? cfg_epoch : frozen_sim_q;

	// running time at this wall time, saturated
	assign a0e = {{2{a0[TW-1]}}, a0};
	assign qe = {2'b00, q_s4};
	assign sum = neg_s4 ? (a0e - qe) : (a0e + qe);
	assign ovf = big_s4 || (sum[TW+1:TW-1] != {3{sum[TW-1]}});
	assign sat_neg = big_s4 ? neg_s4 : sum[TW+1];
	assign s_val = ovf ? (sat_neg ? T_MIN : T_MAX) : sum[TW-1:0];

	assign f1 = ops_s4.set_epoch ? arg_s4 : (ops_s4.freeze ? s_val : f0);
	assign a1 = ops_s4.set_epoch ? arg_s4 :
		(ops_s4.reanchor ? s_val : (ops_s4.resume ? f1 : a0));
	assign sim_n = ops_s4.paused ? f1 :
		((ops_s4.resume || ops_s4.set_epoch) ? a1 : s_val);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			anchor_sim_q <= '0;
			frozen_sim_q <= '0;
		end else if (take) begin
			anchor_sim_q <= a1;
			frozen_sim_q <= f1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			sim_time_ms <= sim_n;
			epoch_ms <= epoch_s4;
			rate_scale <= scale_s4;
			is_paused <= ops_s4.paused;
			pause_pending <= ops_s4.armed;
			pending_wall_ms <= pend_s4;
			bad_scale <= ops_s4.bad;
		end
	end

	`SPT_ASSERT(a_bad_no_op, take && ops_s4.bad |-> !(ops_s4.freeze || ops_s4.reanchor || ops_s4.resume || ops_s4.set_epoch), "rejected scale changed the time state")

endmodule
